### rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared widths, command and status codes, bus phase encoding and the
// classified tick item that passes from the front end to the sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int REQ_W   = 3;
    localparam int ADDR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 16;
    localparam int RETRY_W = 8;
    localparam int STAT_W  = 2;
    localparam int BIT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Depth of the queue between front end and sequencer
    localparam int QUEUE_DEPTH_DEF = 2;

    // Register reset values
    localparam logic [CNT_W-1:0]   TPD_RESET   = 16'd80;
    localparam logic [CNT_W-1:0]   TMO_RESET   = 16'd65535;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT     = 2'd2;

    // Request codes as they arrive on the input channel
    localparam logic [REQ_W-1:0] REQ_NONE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADDR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd5;

    // Completion status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ADDR_NACK = 2'd1;
    localparam logic [STAT_W-1:0] ST_DATA_NACK = 2'd2;

    localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_ADDR    = 3'd3,
        CMD_WR_BYTE = 3'd4,
        CMD_RD_BYTE = 3'd5
    } cmd_t;

    typedef enum logic [14:0] {
        PH_IDLE       = 15'h0001,
        PH_START1     = 15'h0002,
        PH_START2     = 15'h0004,
        PH_BIT_SETUP  = 15'h0008,
        PH_BIT_HIGH   = 15'h0010,
        PH_BIT_LOW    = 15'h0020,
        PH_ACK_SETUP  = 15'h0040,
        PH_ACK_HIGH   = 15'h0080,
        PH_ACK_POLL   = 15'h0100,
        PH_STOP1      = 15'h0200,
        PH_STOP2      = 15'h0400,
        PH_RD_LOW     = 15'h0800,
        PH_RD_HIGH    = 15'h1000,
        PH_RACK_SETUP = 15'h2000,
        PH_RACK_HIGH  = 15'h4000
    } phase_t;

    // One classified timebase tick
    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] addr_byte;
        logic [BYTE_W-1:0] tx_byte;
        logic              read_ack;
        logic              sda_in;
    } tick_t;

    // Engine configuration as seen by the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]   ticks_per_delay;
        logic [CNT_W-1:0]   ack_timeout;
        logic [RETRY_W-1:0] retry_limit;
    } cfg_t;

endpackage

### rtl/i2cm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine channel interfaces
// Tick input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
    logic                       valid;
    logic                       ready;
    logic [i2cm_pkg::REQ_W-1:0] req_type;
    logic [i2cm_pkg::ADDR_W-1:0] dev_addr;
    logic                       rw_bit;
    logic [i2cm_pkg::BYTE_W-1:0] tx_byte;
    logic                       read_ack;
    logic                       sda_in;

    modport source (output valid, req_type, dev_addr, rw_bit, tx_byte, read_ack, sda_in,
                    input ready);
    modport sink (input valid, req_type, dev_addr, rw_bit, tx_byte, read_ack, sda_in,
                  output ready);
endinterface

interface i2cm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        scl_out;
    logic                        sda_out;
    logic                        sda_oe;
    logic                        busy_res;
    logic                        done_res;
    logic [i2cm_pkg::STAT_W-1:0] status;
    logic [i2cm_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, scl_out, sda_out, sda_oe, busy_res, done_res, status,
                    rx_byte, input ready);
    modport sink (input valid, scl_out, sda_out, sda_oe, busy_res, done_res, status,
                  rx_byte, output ready);
endinterface

interface i2cm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [i2cm_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [i2cm_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

### rtl/i2c_master_byte_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine
// Bit-level I2C master: start, stop, address phase with retries, byte write
// with acknowledge timeout and byte read with ACK or NACK plus stop.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   in_ch    | in  | valid / ready | req_type dev_addr rw_bit tx_byte read_ack
//            |     |               | sda_in
//   out_ch   | out | valid / ready | scl_out sda_out sda_oe busy_res done_res
//            |     |               | status rx_byte
//   cfg      | in  | valid / ready | reg_index wdata (ready held high)
//
// Every input item is one bus timebase tick and yields exactly one result item.
// Throughput is one item per clock unless the output stalls, set by the sequencer's phase
// update; an item passes through the queue write, then the registered result slot.
// Reset is asynchronous and active low; there is no clearing pass, so items are
// accepted straight after reset.
// A stalled output holds the result slot and halts the sequencer; the front end
// keeps taking items until the queue (QUEUE_DEPTH items) is full.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cm_in_if.sink     in_ch,
    i2cm_out_if.source  out_ch,
    i2cm_cfg_if.sink    cfg
);
    import i2cm_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0]   tpd_reg;
    logic [CNT_W-1:0]   tmo_reg;
    logic [RETRY_W-1:0] retry_reg;
    cfg_t               cfg_vals;

    // Front end to queue, queue to sequencer
    logic  q_space;
    logic  push;
    tick_t push_item;
    logic  q_avail;
    logic  pop;
    tick_t pop_item;

    // Always take configuration writes; indexes past the list are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpd_reg   <= TPD_RESET;
            tmo_reg   <= TMO_RESET;
            retry_reg <= RETRY_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                CFG_TICKS_PER_DELAY: tpd_reg   <= cfg.wdata;
                CFG_ACK_TIMEOUT:     tmo_reg   <= cfg.wdata;
                CFG_RETRY_LIMIT:     retry_reg <= cfg.wdata[RETRY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_vals.ticks_per_delay = tpd_reg;
        cfg_vals.ack_timeout     = tmo_reg;
        cfg_vals.retry_limit     = retry_reg;
    end

    // Accept and classify ticks
    i2cm_front u_front (
        .in_ch     (in_ch),
        .q_space   (q_space),
        .push      (push),
        .push_item (push_item)
    );

    // Decouple acceptance from the sequencer
    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .space     (q_space),
        .pop       (pop),
        .avail     (q_avail),
        .pop_item  (pop_item)
    );

    // Drive the bus phases and hold the result slot
    i2cm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_vals),
        .tick_avail (q_avail),
        .tick       (pop_item),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

### rtl/i2cm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master front end
// Accept ticks while the queue has room and classify the request field.
// ----------------------------------------------------------------------------
module i2cm_front (
    i2cm_in_if.sink        in_ch,
    input  logic           q_space,
    output logic           push,
    output i2cm_pkg::tick_t push_item
);
    import i2cm_pkg::*;

    cmd_t cmd;

    // Fold unknown request codes into no request
    always_comb
    begin
        case (in_ch.req_type)
            REQ_START: cmd = CMD_START;
            REQ_STOP:  cmd = CMD_STOP;
            REQ_ADDR:  cmd = CMD_ADDR;
            REQ_WRITE: cmd = CMD_WR_BYTE;
            REQ_READ:  cmd = CMD_RD_BYTE;
            default:   cmd = CMD_NONE;
        endcase
    end

    assign in_ch.ready = q_space;
    assign push        = in_ch.valid && q_space;

    always_comb
    begin
        push_item.cmd       = cmd;
        push_item.addr_byte = {in_ch.dev_addr, in_ch.rw_bit};
        push_item.tx_byte   = in_ch.tx_byte;
        push_item.read_ack  = in_ch.read_ack;
        push_item.sda_in    = in_ch.sda_in;
    end

endmodule

### rtl/i2cm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master tick queue
// Short first-in first-out store between front end and sequencer.
// ----------------------------------------------------------------------------
module i2cm_queue #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cm_pkg::tick_t push_item,
    output logic            space,
    input  logic            pop,
    output logic            avail,
    output i2cm_pkg::tick_t pop_item
);
    import i2cm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    tick_t             store [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign space    = (count_reg != FULL_CNT);
    assign avail    = (count_reg != '0);
    assign pop_item = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - CNT_QW'(1)))
        else $error("queue count did not drop on pop");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

### rtl/i2cm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Advance the bus phase machine by one tick per queued item and register
// the bus levels and status as one result item.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  i2cm_pkg::cfg_t  cfg,
    input  logic            tick_avail,
    input  i2cm_pkg::tick_t tick,
    output logic            pop,
    i2cm_out_if.source      out_ch
);
    import i2cm_pkg::*;

    phase_t              phase_reg, phase_next;
    cmd_t                kind_reg, kind_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [BYTE_W-1:0]   shifter_reg, shifter_next;
    logic [CNT_W-1:0]    delay_reg, delay_next;
    logic [CNT_W-1:0]    ackw_reg, ackw_next;
    logic [RETRY_W-1:0]  retries_reg, retries_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                drive_reg, drive_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [BYTE_W-1:0]   addr_byte_reg, addr_byte_next;
    logic                rack_reg, rack_next;
    logic [BYTE_W-1:0]   rx_reg, rx_next;
    logic                done;

    logic [CNT_W-1:0]    load_val;
    logic [CNT_W-1:0]    tmo_lim;
    logic [CNT_W-1:0]    ackw_inc;
    logic [BIT_W-1:0]    bit_inc;
    logic [BYTE_W-1:0]   shifted;
    logic                expired;

    logic                out_valid_reg;
    logic                res_scl_reg, res_sda_reg, res_oe_reg, res_busy_reg, res_done_reg;
    logic [STAT_W-1:0]   res_status_reg;
    logic [BYTE_W-1:0]   res_rx_reg;

    assign load_val = (cfg.ticks_per_delay == '0) ? CNT_W'(1) : cfg.ticks_per_delay;
    assign tmo_lim  = (cfg.ack_timeout == '0) ? CNT_W'(1) : cfg.ack_timeout;
    assign ackw_inc = ackw_reg + CNT_W'(1);
    assign bit_inc  = bit_reg + BIT_W'(1);
    assign shifted  = {shifter_reg[BYTE_W-2:0], 1'b0};
    assign expired  = (delay_reg <= CNT_W'(1));

    // Take a tick whenever the result slot is free or being emptied
    assign pop = tick_avail && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        bit_next       = bit_reg;
        shifter_next   = shifter_reg;
        delay_next     = delay_reg;
        ackw_next      = ackw_reg;
        retries_next   = retries_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drive_next     = drive_reg;
        status_next    = status_reg;
        addr_byte_next = addr_byte_reg;
        rack_next      = rack_reg;
        rx_next        = rx_reg;
        done           = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            case (tick.cmd)
                CMD_START, CMD_ADDR:
                begin
                    kind_next  = tick.cmd;
                    drive_next = 1'b1;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_START1;
                    delay_next = load_val;
                    if (tick.cmd == CMD_ADDR)
                    begin
                        addr_byte_next = tick.addr_byte;
                        retries_next   = cfg.retry_limit;
                    end
                end
                CMD_STOP:
                begin
                    kind_next  = CMD_STOP;
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_STOP1;
                    delay_next = load_val;
                end
                CMD_WR_BYTE:
                begin
                    kind_next    = CMD_WR_BYTE;
                    shifter_next = tick.tx_byte;
                    bit_next     = '0;
                    drive_next   = 1'b1;
                    sda_next     = tick.tx_byte[BYTE_W-1];
                    phase_next   = PH_BIT_SETUP;
                    delay_next   = load_val;
                end
                CMD_RD_BYTE:
                begin
                    kind_next    = CMD_RD_BYTE;
                    rack_next    = tick.read_ack;
                    shifter_next = '0;
                    bit_next     = '0;
                    drive_next   = 1'b0;
                    scl_next     = 1'b0;
                    phase_next   = PH_RD_LOW;
                    delay_next   = load_val;
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg == PH_ACK_POLL)
        begin
            if (!tick.sda_in)
            begin
                scl_next    = 1'b0;
                phase_next  = PH_IDLE;
                status_next = ST_OK;
                done        = 1'b1;
            end
            else
            begin
                ackw_next = ackw_inc;
                if (ackw_inc >= tmo_lim)
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_STOP1;
                    delay_next = load_val;
                end
            end
        end
        else if (!expired)
        begin
            delay_next = delay_reg - CNT_W'(1);
        end
        else
        begin
            delay_next = '0;
            case (phase_reg)
                PH_START1:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_START2;
                    delay_next = load_val;
                end
                PH_START2:
                begin
                    scl_next = 1'b0;
                    if (kind_reg == CMD_ADDR)
                    begin
                        shifter_next = addr_byte_reg;
                        bit_next     = '0;
                        drive_next   = 1'b1;
                        sda_next     = addr_byte_reg[BYTE_W-1];
                        phase_next   = PH_BIT_SETUP;
                        delay_next   = load_val;
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        status_next = ST_OK;
                        done        = 1'b1;
                    end
                end
                PH_BIT_SETUP:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_BIT_HIGH;
                    delay_next = load_val;
                end
                PH_BIT_HIGH:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_BIT_LOW;
                    delay_next = load_val;
                end
                PH_BIT_LOW:
                begin
                    bit_next     = bit_inc;
                    shifter_next = shifted;
                    delay_next   = load_val;
                    if (bit_inc < BITS_PER_BYTE)
                    begin
                        sda_next   = shifted[BYTE_W-1];
                        phase_next = PH_BIT_SETUP;
                    end
                    else
                    begin
                        sda_next   = 1'b1;
                        drive_next = 1'b0;
                        phase_next = PH_ACK_SETUP;
                    end
                end
                PH_ACK_SETUP:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_ACK_HIGH;
                    delay_next = load_val;
                end
                PH_ACK_HIGH:
                begin
                    ackw_next  = '0;
                    phase_next = PH_ACK_POLL;
                end
                PH_STOP1:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_STOP2;
                    delay_next = load_val;
                end
                PH_STOP2:
                begin
                    if (kind_reg == CMD_ADDR && retries_reg != '0)
                    begin
                        retries_next = retries_reg - RETRY_W'(1);
                        drive_next   = 1'b1;
                        scl_next     = 1'b1;
                        sda_next     = 1'b1;
                        phase_next   = PH_START1;
                        delay_next   = load_val;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        if (kind_reg == CMD_ADDR)
                        begin
                            status_next = ST_ADDR_NACK;
                        end
                        else if (kind_reg == CMD_WR_BYTE)
                        begin
                            status_next = ST_DATA_NACK;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            if (kind_reg == CMD_RD_BYTE)
                            begin
                                rx_next = shifter_reg;
                            end
                        end
                    end
                end
                PH_RD_LOW:
                begin
                    scl_next     = 1'b1;
                    shifter_next = {shifter_reg[BYTE_W-2:0], tick.sda_in};
                    phase_next   = PH_RD_HIGH;
                    delay_next   = load_val;
                end
                PH_RD_HIGH:
                begin
                    bit_next   = bit_inc;
                    scl_next   = 1'b0;
                    delay_next = load_val;
                    if (bit_inc < BITS_PER_BYTE)
                    begin
                        phase_next = PH_RD_LOW;
                    end
                    else
                    begin
                        drive_next = 1'b1;
                        sda_next   = !rack_reg;
                        phase_next = PH_RACK_SETUP;
                    end
                end
                PH_RACK_SETUP:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RACK_HIGH;
                    delay_next = load_val;
                end
                PH_RACK_HIGH:
                begin
                    scl_next = 1'b0;
                    if (rack_reg)
                    begin
                        rx_next     = shifter_reg;
                        phase_next  = PH_IDLE;
                        status_next = ST_OK;
                        done        = 1'b1;
                    end
                    else
                    begin
                        drive_next = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PH_STOP1;
                        delay_next = load_val;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= CMD_NONE;
            bit_reg       <= '0;
            shifter_reg   <= '0;
            delay_reg     <= '0;
            ackw_reg      <= '0;
            retries_reg   <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b1;
            status_reg    <= ST_OK;
            addr_byte_reg <= '0;
            rack_reg      <= 1'b0;
            rx_reg        <= '0;
        end
        else if (pop)
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            bit_reg       <= bit_next;
            shifter_reg   <= shifter_next;
            delay_reg     <= delay_next;
            ackw_reg      <= ackw_next;
            retries_reg   <= retries_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drive_reg     <= drive_next;
            status_reg    <= status_next;
            addr_byte_reg <= addr_byte_next;
            rack_reg      <= rack_next;
            rx_reg        <= rx_next;
        end
    end

    // Result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_scl_reg    <= scl_next;
            res_sda_reg    <= drive_next & sda_next;
            res_oe_reg     <= drive_next;
            res_busy_reg   <= (phase_next != PH_IDLE);
            res_done_reg   <= done;
            res_status_reg <= status_next;
            res_rx_reg     <= rx_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.scl_out  = res_scl_reg;
    assign out_ch.sda_out  = res_sda_reg;
    assign out_ch.sda_oe   = res_oe_reg;
    assign out_ch.busy_res = res_busy_reg;
    assign out_ch.done_res = res_done_reg;
    assign out_ch.status   = res_status_reg;
    assign out_ch.rx_byte  = res_rx_reg;

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!out_valid_reg || out_ch.ready))
        else $error("tick taken while result slot is held");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && done) |=> (out_ch.done_res && !out_ch.busy_res))
        else $error("finished command still reported busy");

    a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.sda_oe) |-> !out_ch.sda_out)
        else $error("sda_out high while SDA released");

    a_poll_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ACK_POLL) |-> (delay_reg == '0))
        else $error("delay counter live during acknowledge poll");

endmodule
